>>> rtl/tpp_pkg.sv
// Shared types and constants for the trackball point projection.
// No dependencies; used by the top level and its port checker.
`timescale 1ns / 1ps

package tpp_pkg;

    // Q1.14 unit value
    localparam int Q_ONE = 16384;

    // Cycles from an accepted start to its result strobe
    localparam int LATENCY = 23;

    // Bits of the root found by the shift-add square-root stages
    localparam int ROOT_BITS = 16;

    typedef struct packed {
        logic [9:0] pixel_col;
        logic [9:0] pixel_row;
    } t_item;

    typedef struct packed {
        logic signed [15:0] ball_x;
        logic signed [15:0] ball_y;
        logic        [14:0] ball_z;
    } t_result;

endpackage

>>> rtl/trackball_point_projection.sv
// o_strobe is the last bit of the valid chain and rises together with the registered o_result.
// Throughput: one item per cycle; busy stays low, the receiver cannot stall.
// The 16 shift-add root stages set the depth; each resolves one root bit.
// Reset (synchronous, active low) clears the valid chain; data registers hold no reset.
// Depends on tpp_pkg.
`timescale 1ns / 1ps

module trackball_point_projection
    import tpp_pkg::*;
#(
    parameter int PIX_COLS = 600,
    parameter int PIX_ROWS = 600
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_item   i_item,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    // Valid chain, one bit per register stage
    logic [LATENCY-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LATENCY-2:0], start};
        end
    end

    assign busy     = 1'b0;
    assign o_strobe = r_vld[LATENCY-1];

    // Per-axis results handed to the combine stage
    logic        [28:0] r5_sq   [2];
    logic signed [15:0] r5_ball [2];

    // Map each axis: clamp, divide by the span through a reciprocal, square
    for (genvar g = 0; g < 2; g++) begin : g_axis
        localparam int SPAN  = (g == 0) ? PIX_COLS - 1 : PIX_ROWS - 1;
        localparam int RECIP = (1 << 26) / SPAN;
        localparam logic [11:0] SPAN_V  = 12'(SPAN);
        localparam logic [26:0] RECIP_V = 27'(RECIP);
        localparam logic [25:0] HALF_V  = 26'(SPAN / 2);

        logic [9:0]  pix;
        logic [11:0] pclamp;
        logic [12:0] twice;
        logic [11:0] mag;
        logic        neg;
        logic [25:0] n_num;
        logic [26:0] rem;
        logic [14:0] n_q;

        logic [25:0] r1_num, r2_num, r3_num;
        logic        r1_neg, r2_neg, r3_neg, r4_neg;
        logic [52:0] r2_prod;
        logic [14:0] r3_q0;
        logic [26:0] r3_qs;
        logic [14:0] r4_mag;

        assign pix = (g == 0) ? i_item.pixel_col : i_item.pixel_row;

        // Clamp to the canvas and fold around the center
        always_comb begin
            pclamp = ({2'b00, pix} > SPAN_V) ? SPAN_V : {2'b00, pix};
            twice  = {pclamp, 1'b0};
            if (twice >= {1'b0, SPAN_V}) begin
                mag = 12'(twice - {1'b0, SPAN_V});
                neg = 1'b0;
            end else begin
                mag = 12'({1'b0, SPAN_V} - twice);
                neg = 1'b1;
            end
            n_num = {mag, 14'b0} + HALF_V;
        end

        // Correct the reciprocal quotient by one compare
        always_comb begin
            rem = {1'b0, r3_num} - r3_qs;
            n_q = (rem >= 27'(SPAN_V)) ? r3_q0 + 15'd1 : r3_q0;
        end

        // Advance the axis stages
        always_ff @(posedge i_clk) begin
            r1_num     <= n_num;
            r1_neg     <= (g == 0) ? neg : !neg;
            r2_prod    <= 53'(r1_num) * 53'(RECIP_V);
            r2_num     <= r1_num;
            r2_neg     <= r1_neg;
            r3_q0      <= r2_prod[40:26];
            r3_qs      <= 27'(r2_prod[40:26]) * 27'(SPAN_V);
            r3_num     <= r2_num;
            r3_neg     <= r2_neg;
            r4_mag     <= n_q;
            r4_neg     <= r3_neg;
            r5_sq[g]   <= 29'(30'(r4_mag) * 30'(r4_mag));
            r5_ball[g] <= r4_neg ? -$signed({1'b0, r4_mag}) : $signed({1'b0, r4_mag});
        end
    end

    // Root stage registers; index 0 is loaded by the combine stage
    logic [29:0]           r_a [ROOT_BITS+1];
    logic [56:0]           r_b [ROOT_BITS+1];
    logic [56:0]           r_p [ROOT_BITS+1];
    logic [46:0]           r_q [ROOT_BITS+1];
    logic [ROOT_BITS-1:0]  r_w [ROOT_BITS+1];
    logic signed [15:0]    r_x [ROOT_BITS+1];
    logic signed [15:0]    r_y [ROOT_BITS+1];

    logic [29:0] d_sum;
    logic        sphere;

    // Pick sphere or sheet: find the largest w with w*w*A <= B
    always_comb begin
        d_sum  = 30'(r5_sq[0]) + 30'(r5_sq[1]);
        sphere = d_sum <= 30'(1 << 27);
    end

    always_ff @(posedge i_clk) begin
        r_a[0] <= sphere ? 30'd1 : d_sum;
        r_b[0] <= sphere ? 57'(1 << 30) - {25'b0, d_sum, 2'b00} : 57'(1) << 56;
        r_p[0] <= '0;
        r_q[0] <= '0;
        r_w[0] <= '0;
        r_x[0] <= r5_ball[0];
        r_y[0] <= r5_ball[1];
    end

    // One root bit per stage, from the top bit down
    for (genvar i = 0; i < ROOT_BITS; i++) begin : g_root
        localparam int K = ROOT_BITS - 1 - i;

        logic [61:0] trial;
        logic        take;

        always_comb begin
            trial = 62'(r_p[i]) + (62'(r_q[i]) << (K + 1)) + (62'(r_a[i]) << (2 * K));
            take  = trial <= 62'(r_b[i]);
        end

        always_ff @(posedge i_clk) begin
            r_a[i+1] <= r_a[i];
            r_b[i+1] <= r_b[i];
            r_p[i+1] <= take ? 57'(trial) : r_p[i];
            r_q[i+1] <= take ? r_q[i] + (47'(r_a[i]) << K) : r_q[i];
            r_w[i+1] <= take ? r_w[i] | (ROOT_BITS'(1) << K) : r_w[i];
            r_x[i+1] <= r_x[i];
            r_y[i+1] <= r_y[i];
        end
    end

    // Round the doubled root to the final height
    logic [ROOT_BITS:0] zsum;

    assign zsum = {1'b0, r_w[ROOT_BITS]} + (ROOT_BITS+1)'(1);

    always_ff @(posedge i_clk) begin
        o_result.ball_x <= r_x[ROOT_BITS];
        o_result.ball_y <= r_y[ROOT_BITS];
        o_result.ball_z <= zsum[15:1];
    end

endmodule

>>> rtl/tpp_checker.sv
// Port checker for the trackball point projection, bound to the top level.
// Depends on tpp_pkg and trackball_point_projection.
`timescale 1ns / 1ps

module tpp_checker
    import tpp_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_strobe,
    input t_result o_result
);

    // Never hold off the sender
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    // Every item yields its result after the fixed latency
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##(LATENCY) o_strobe)
        else $error("result missing");

    // No result without an item taken earlier
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, LATENCY))
        else $error("result without item");

    // Keep x and y within plus or minus one and z at most one (Q1.14)
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.ball_z <= 15'(Q_ONE)
                      && o_result.ball_x <= 16'sd16384 && o_result.ball_x >= -16'sd16384
                      && o_result.ball_y <= 16'sd16384 && o_result.ball_y >= -16'sd16384))
        else $error("result out of range");

endmodule

bind trackball_point_projection tpp_checker u_tpp_checker (.*);
